>>> rtl/ett_pkg.sv
// Shared types, codes and helpers for the event trap table.
package ett_pkg;

    localparam int unsigned CMD_W  = 4;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned SUB_W  = 8;
    localparam int unsigned HDL_W  = 16;
    localparam int unsigned TPS_W  = 16;
    localparam int unsigned ELAP_W = 32;

    localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ENABLE   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_DISABLE  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SUSPEND  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_EN_ALL   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DIS_ALL  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SUSP_ALL = 4'd6;
    localparam logic [CMD_W-1:0] CMD_KEY      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_PEN      = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ERROR    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_TRIGGER  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_TICK     = 4'd11;
    localparam logic [CMD_W-1:0] CMD_POLL     = 4'd12;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd13;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_KEY   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TIMER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEN   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PLAY  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LAST  = 3'd6;

    // scan codes
    localparam logic [7:0] SC_F1    = 8'd58;
    localparam logic [7:0] SC_F10   = 8'd67;
    localparam logic [7:0] SC_UP    = 8'd82;
    localparam logic [7:0] SC_LEFT  = 8'd80;
    localparam logic [7:0] SC_RIGHT = 8'd79;
    localparam logic [7:0] SC_DOWN  = 8'd81;
    localparam logic [7:0] SC_INS   = 8'd73;
    localparam logic [7:0] SC_DEL   = 8'd76;
    localparam logic [7:0] SC_HOME  = 8'd74;
    localparam logic [7:0] SC_END   = 8'd77;
    localparam logic [7:0] SC_PGUP  = 8'd75;
    localparam logic [7:0] SC_PGDN  = 8'd78;

    // key numbers
    localparam logic [SUB_W-1:0] KEY_NONE     = 8'd0;
    localparam logic [SUB_W-1:0] KEY_UP       = 8'd11;
    localparam logic [SUB_W-1:0] KEY_LEFT     = 8'd12;
    localparam logic [SUB_W-1:0] KEY_RIGHT    = 8'd13;
    localparam logic [SUB_W-1:0] KEY_DOWN     = 8'd14;
    localparam logic [SUB_W-1:0] KEY_INS      = 8'd15;
    localparam logic [SUB_W-1:0] KEY_DEL      = 8'd16;
    localparam logic [SUB_W-1:0] KEY_CUR_HOME = 8'd17;
    localparam logic [SUB_W-1:0] KEY_END      = 8'd18;
    localparam logic [SUB_W-1:0] KEY_PGUP     = 8'd19;
    localparam logic [SUB_W-1:0] KEY_PGDN     = 8'd20;

    typedef enum logic [3:0] {
        OP_NONE, OP_SET, OP_EN, OP_DIS, OP_SUSP, OP_EN_ALL, OP_DIS_ALL,
        OP_SUSP_ALL, OP_RAISE, OP_TICK, OP_POLL, OP_CLEAR
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_TCHK, S_LOOK, S_APPLY, S_PSCAN, S_PDATA,
        S_SUM, S_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KIND_W-1:0] event_kind;
        logic [SUB_W-1:0]  sub_event;
        logic [HDL_W-1:0]  handler_in;
        logic [15:0]       interval_seconds;
        logic [7:0]        scan_code;
        logic              pressed;
    } t_req;

    typedef struct packed {
        logic [HDL_W-1:0]  handler_out;
        logic [KIND_W-1:0] fired_kind;
        logic [SUB_W-1:0]  fired_sub;
        logic              table_full;
        logic              any_active;
        logic              any_pending;
    } t_rsp;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SUB_W-1:0]  sub;
        logic [HDL_W-1:0]  handler;
    } t_slot;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic idx_clr;
        logic look;
        logic apply;
        logic tchk;
        logic pscan;
        logic pdata;
        logic sum;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic look_done;
        logic timer_due;
        logic pscan_hit;
        logic scan_end;
    } t_sts;

    function automatic logic [SUB_W-1:0] key_of_scan(input logic [7:0] sc);
        logic [SUB_W-1:0] k;
        k = KEY_NONE;
        if (sc >= SC_F1 && sc <= SC_F10) begin
            k = sc - (SC_F1 - 8'd1);
        end else begin
            case (sc)
                SC_UP:    k = KEY_UP;
                SC_LEFT:  k = KEY_LEFT;
                SC_RIGHT: k = KEY_RIGHT;
                SC_DOWN:  k = KEY_DOWN;
                SC_INS:   k = KEY_INS;
                SC_DEL:   k = KEY_DEL;
                SC_HOME:  k = KEY_CUR_HOME;
                SC_END:   k = KEY_END;
                SC_PGUP:  k = KEY_PGUP;
                SC_PGDN:  k = KEY_PGDN;
                default:  k = KEY_NONE;
            endcase
        end
        return k;
    endfunction

endpackage

>>> rtl/ett_ctrl.sv
// Sequencing state machine for the event trap table.
module ett_ctrl
    import ett_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output logic o_strobe,
    output t_ctl o_ctl,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_POLL: n_state = S_TCHK;
                    OP_SET, OP_EN, OP_DIS, OP_SUSP, OP_RAISE: n_state = S_LOOK;
                    default: n_state = S_APPLY;
                endcase
            end
            S_TCHK: begin
                n_state = i_sts.timer_due ? S_LOOK : S_PSCAN;
            end
            S_LOOK: begin
                if (i_sts.look_done) n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = (i_sts.op == OP_POLL) ? S_PSCAN : S_SUM;
            end
            S_PSCAN: begin
                if (i_sts.pscan_hit) n_state = S_PDATA;
                else if (i_sts.scan_end) n_state = S_SUM;
            end
            S_PDATA: n_state = S_SUM;
            S_SUM: begin
                if (i_sts.scan_end) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl    = '0;
        busy     = 1'b1;
        o_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy        = 1'b0;
                o_ctl.latch = start;
            end
            S_DISPATCH: o_ctl.idx_clr = 1'b1;
            S_TCHK: begin
                o_ctl.tchk    = 1'b1;
                o_ctl.idx_clr = 1'b1;
            end
            S_LOOK: o_ctl.look = 1'b1;
            S_APPLY: begin
                o_ctl.apply   = 1'b1;
                o_ctl.idx_clr = 1'b1;
            end
            S_PSCAN: begin
                o_ctl.pscan   = 1'b1;
                o_ctl.idx_clr = i_sts.scan_end && !i_sts.pscan_hit;
            end
            S_PDATA: begin
                o_ctl.pdata   = 1'b1;
                o_ctl.idx_clr = 1'b1;
            end
            S_SUM:  o_ctl.sum = 1'b1;
            S_DONE: o_strobe = 1'b1;
            default: ;
        endcase
    end

    a_strobe_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy)
        else $error("strobe not followed by idle");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !o_strobe) |=> !o_ctl.latch)
        else $error("request latched while working");

    a_look_to_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.look && i_sts.look_done) |=> o_ctl.apply)
        else $error("lookup did not hand over to apply");

endmodule

>>> rtl/ett_datapath.sv
// Slot table, flags, timer and scan logic for the event trap table.
module ett_datapath
    import ett_pkg::*;
#(
    parameter int unsigned TRAP_SLOTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    output t_sts             o_sts,
    input  t_req             i_request,
    input  logic             i_cfg_we,
    input  logic [TPS_W-1:0] i_cfg_data,
    output t_rsp             o_result
);

    localparam int unsigned IDX_W = $clog2(TRAP_SLOTS);
    localparam int unsigned CNT_W = $clog2(TRAP_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TRAP_SLOTS);

    // slot key and handler store; read data is used only for entries below the fill count
    t_slot mem [0:TRAP_SLOTS-1];
    t_slot r_mem_q;

    logic [TRAP_SLOTS-1:0] r_en;
    logic [TRAP_SLOTS-1:0] r_susp;
    logic [TRAP_SLOTS-1:0] r_pend;
    logic [CNT_W-1:0]      r_used_cnt;

    logic [TPS_W-1:0]  r_tps;
    logic              r_running;
    logic [15:0]       r_period;
    logic [ELAP_W-1:0] r_elapsed;
    logic [ELAP_W-1:0] r_thresh;

    t_op               r_op;
    logic [KIND_W-1:0] r_kind;
    logic [SUB_W-1:0]  r_sub;
    logic [HDL_W-1:0]  r_handler;
    logic [15:0]       r_interval;

    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;

    logic [HDL_W-1:0]  r_h_out;
    logic [KIND_W-1:0] r_k_out;
    logic [SUB_W-1:0]  r_s_out;
    logic              r_full;
    logic              r_act;
    logic              r_pany;

    t_op               n_op;
    logic [KIND_W-1:0] n_kind;
    logic [SUB_W-1:0]  n_sub;

    logic [IDX_W-1:0]  idx_a;
    logic              scan_end;
    logic              cand;
    logic              pscan_hit;
    logic              lk_hit_now;
    logic              timer_due;
    logic              set_ok;
    logic [IDX_W-1:0]  w_idx;
    logic [SUB_W-1:0]  key_num;
    logic [SUB_W-1:0]  norm_sub;

    // request decode
    always_comb begin
        key_num  = key_of_scan(i_request.scan_code);
        norm_sub = (i_request.event_kind >= KIND_ERROR && i_request.event_kind <= KIND_PLAY)
                   ? '0 : i_request.sub_event;
        n_op   = OP_NONE;
        n_kind = i_request.event_kind;
        n_sub  = norm_sub;
        case (i_request.command)
            CMD_SET:      if (i_request.event_kind <= KIND_LAST) n_op = OP_SET;
            CMD_ENABLE:   if (i_request.event_kind <= KIND_LAST) n_op = OP_EN;
            CMD_DISABLE:  if (i_request.event_kind <= KIND_LAST) n_op = OP_DIS;
            CMD_SUSPEND:  if (i_request.event_kind <= KIND_LAST) n_op = OP_SUSP;
            CMD_EN_ALL:   n_op = OP_EN_ALL;
            CMD_DIS_ALL:  n_op = OP_DIS_ALL;
            CMD_SUSP_ALL: n_op = OP_SUSP_ALL;
            CMD_KEY: begin
                n_kind = KIND_KEY;
                n_sub  = key_num;
                if (i_request.pressed && key_num != KEY_NONE) n_op = OP_RAISE;
            end
            CMD_PEN: begin
                n_kind = KIND_PEN;
                n_sub  = '0;
                if (i_request.pressed) n_op = OP_RAISE;
            end
            CMD_ERROR: begin
                n_kind = KIND_ERROR;
                n_sub  = '0;
                n_op   = OP_RAISE;
            end
            CMD_TRIGGER:  if (i_request.event_kind <= KIND_LAST) n_op = OP_RAISE;
            CMD_TICK:     n_op = OP_TICK;
            CMD_POLL: begin
                // poll searches for the timer slot if the interval ran out
                n_kind = KIND_TIMER;
                n_sub  = '0;
                n_op   = OP_POLL;
            end
            CMD_CLEAR:    n_op = OP_CLEAR;
            default:      n_op = OP_NONE;
        endcase
    end

    assign idx_a      = r_idx[IDX_W-1:0];
    assign scan_end   = (r_idx == r_used_cnt);
    assign cand       = r_pend[idx_a] & r_en[idx_a] & ~r_susp[idx_a];
    assign pscan_hit  = !scan_end && cand;
    assign lk_hit_now = r_rd_vld && (r_mem_q.kind == r_kind) && (r_mem_q.sub == r_sub);
    assign timer_due  = r_running && (r_elapsed >= r_thresh);
    assign set_ok     = r_hit || (r_used_cnt != SLOTS_CNT);
    assign w_idx      = r_hit ? r_hit_idx : r_used_cnt[IDX_W-1:0];

    assign o_sts.op        = r_op;
    assign o_sts.look_done = lk_hit_now || (scan_end && !r_rd_vld);
    assign o_sts.timer_due = timer_due;
    assign o_sts.pscan_hit = pscan_hit;
    assign o_sts.scan_end  = scan_end;

    // request latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_NONE;
        end else if (i_ctl.latch) begin
            r_op <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_kind     <= n_kind;
            r_sub      <= n_sub;
            r_handler  <= i_request.handler_in;
            r_interval <= i_request.interval_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_data;
        end
    end

    // slot store: one write in apply, one registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (i_ctl.apply && r_op == OP_SET && set_ok) begin
            mem[w_idx] <= '{kind: r_kind, sub: r_sub, handler: r_handler};
        end
        r_mem_q <= mem[idx_a];
    end

    // scan index and lookup result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_idx  <= '0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
        end else if (i_ctl.idx_clr) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else if (i_ctl.look) begin
            if (!scan_end) r_idx <= r_idx + 1'b1;
            r_rd_vld <= !scan_end;
            r_rd_idx <= idx_a;
            if (lk_hit_now && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
            end
        end else if (i_ctl.pscan) begin
            // hold on a hit so the store read lands on the fired slot
            if (!scan_end && !cand) r_idx <= r_idx + 1'b1;
        end else if (i_ctl.sum) begin
            if (!scan_end) r_idx <= r_idx + 1'b1;
        end
    end

    // per-slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= '0;
            r_susp <= '0;
            r_pend <= '0;
        end else if (i_ctl.apply) begin
            case (r_op)
                OP_SET: begin
                    if (set_ok) begin
                        r_en[w_idx]   <= 1'b1;
                        r_susp[w_idx] <= 1'b0;
                        r_pend[w_idx] <= 1'b0;
                    end
                end
                OP_EN: begin
                    if (r_hit) begin
                        r_en[r_hit_idx]   <= 1'b1;
                        r_susp[r_hit_idx] <= 1'b0;
                    end
                end
                OP_DIS: begin
                    if (r_hit) begin
                        r_en[r_hit_idx]   <= 1'b0;
                        r_susp[r_hit_idx] <= 1'b0;
                        r_pend[r_hit_idx] <= 1'b0;
                    end
                end
                OP_SUSP: begin
                    if (r_hit) r_susp[r_hit_idx] <= 1'b1;
                end
                OP_EN_ALL: begin
                    r_en   <= '1;
                    r_susp <= '0;
                end
                OP_DIS_ALL, OP_CLEAR: begin
                    r_en   <= '0;
                    r_susp <= '0;
                    r_pend <= '0;
                end
                OP_SUSP_ALL: r_susp <= '1;
                OP_RAISE, OP_POLL: begin
                    if (r_hit && r_en[r_hit_idx] && !r_susp[r_hit_idx]) begin
                        r_pend[r_hit_idx] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (i_ctl.pscan && pscan_hit) begin
            r_pend[idx_a] <= 1'b0;
        end
    end

    // fill count and timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_cnt <= '0;
            r_running  <= 1'b0;
            r_period   <= '0;
            r_elapsed  <= '0;
        end else if (i_ctl.apply) begin
            case (r_op)
                OP_SET: begin
                    if (set_ok && !r_hit) r_used_cnt <= r_used_cnt + 1'b1;
                    if (set_ok && r_kind == KIND_TIMER) begin
                        r_period  <= r_interval;
                        r_elapsed <= '0;
                        r_running <= 1'b1;
                    end
                end
                OP_DIS_ALL: r_running <= 1'b0;
                OP_CLEAR: begin
                    r_used_cnt <= '0;
                    r_running  <= 1'b0;
                end
                OP_TICK: begin
                    if (r_elapsed != '1) r_elapsed <= r_elapsed + 1'b1;
                end
                default: ;
            endcase
        end else if (i_ctl.tchk && timer_due) begin
            r_elapsed <= '0;
        end
    end

    // firing threshold, registered from the period and the tick rate
    always_ff @(posedge i_clk) begin
        r_thresh <= ELAP_W'({16'b0, r_period} * {16'b0, r_tps});
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_h_out <= '0;
            r_k_out <= '0;
            r_s_out <= '0;
            r_full  <= 1'b0;
            r_act   <= 1'b0;
            r_pany  <= 1'b0;
        end else begin
            if (i_ctl.apply && r_op == OP_SET && !set_ok) r_full <= 1'b1;
            if (i_ctl.pdata) begin
                r_h_out <= r_mem_q.handler;
                r_k_out <= r_mem_q.kind;
                r_s_out <= r_mem_q.sub;
            end
            if (i_ctl.sum && !scan_end) begin
                r_act  <= r_act | (r_en[idx_a] & ~r_susp[idx_a]);
                r_pany <= r_pany | cand;
            end
        end
    end

    assign o_result.handler_out = r_h_out;
    assign o_result.fired_kind  = r_k_out;
    assign o_result.fired_sub   = r_s_out;
    assign o_result.table_full  = r_full;
    assign o_result.any_active  = r_act;
    assign o_result.any_pending = r_pany;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= SLOTS_CNT)
        else $error("fill count beyond table size");

    a_timer_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.tchk && timer_due) |=> (r_elapsed == '0))
        else $error("timer fired without restart");

    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.pscan && pscan_hit) |=> !r_pend[$past(idx_a)])
        else $error("fired slot still pending");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_used_cnt)
        else $error("scan index past fill count");

endmodule

>>> rtl/event_trap_table_top.sv
// Top level of the event trap table: controller plus datapath.
//
//   channel   direction  handshake           payload
//   request   in         start / busy        i_request  (t_req)
//   result    out        o_strobe            o_result   (t_rsp)
//   config    in         i_cfg_we            i_cfg_data (ticks per second)
//
// A request is taken when start is high and busy is low; its one result shows
// for a single cycle with o_strobe. A request holds busy through the cycle of
// its strobe. The slot scans step one entry a cycle; the lookup for set, enable,
// disable, suspend and event requests reads keys through the slot store's read
// port, and a poll that fires a slot reads its handler through the same port.
// Synchronous active-low reset empties the table and stops the timer.
// The receiver cannot stall the result.
module event_trap_table_top
    import ett_pkg::*;
#(
    parameter int unsigned TRAP_SLOTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_request,
    output logic             o_strobe,
    output t_rsp             o_result,
    input  logic             i_cfg_we,
    input  logic [TPS_W-1:0] i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    ett_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_ctl    (ctl),
        .i_sts    (sts)
    );

    ett_datapath #(
        .TRAP_SLOTS (TRAP_SLOTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_request  (i_request),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

endmodule

>>> dv/event_trap_table_top_test.sv
// Testbench for event_trap_table_top: directed table, then random phases checked by a predictor.
`timescale 1ns / 100ps

module event_trap_table_top_test;
    import ett_pkg::*;

    localparam int SLOTS    = 32;
    localparam int PHASES   = 7;
    localparam int PHASE_N  = 218;
    localparam int WATCHDOG = 5000;
    localparam int TAIL     = 150;

    // codes the package leaves out, and a local name for its last kind
    localparam logic [CMD_W-1:0]  CMD_SPARE_LO = 4'd14;
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI = 4'd15;
    localparam logic [KIND_W-1:0] KIND_STICK   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SERIAL  = KIND_LAST;
    localparam logic [KIND_W-1:0] KIND_BAD     = 3'd7;

    typedef struct {
        t_req rq;
        bit   typed;
        t_rsp want;
    } t_row;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             start    = 1'b0;
    logic             busy;
    t_req             req      = '0;
    logic             strobe;
    t_rsp             rsp;
    logic             cfg_we   = 1'b0;
    logic [TPS_W-1:0] cfg_data = '0;

    event_trap_table_top #(.TRAP_SLOTS(SLOTS)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_request  (req),
        .o_strobe   (strobe),
        .o_result   (rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor state
    // ---------------------------------------------------------------
    bit                tt_used [SLOTS];
    logic [KIND_W-1:0] tt_kind [SLOTS];
    logic [SUB_W-1:0]  tt_sub  [SLOTS];
    logic [HDL_W-1:0]  tt_line [SLOTS];
    bit                tt_en   [SLOTS];
    bit                tt_susp [SLOTS];
    bit                tt_pend [SLOTS];
    int                tt_count;
    bit                tmr_run;
    logic [15:0]       tmr_secs;
    logic [ELAP_W-1:0] tmr_elapsed;
    logic [TPS_W-1:0]  tps;

    t_rsp trap_outcomes_due[$];
    t_row rows[$];
    int   fail_count   = 0;
    int   quiet_cycles = 0;

    function automatic void model_reset();
        for (int i = 0; i < SLOTS; i++) begin
            tt_used[i] = 0;
            tt_kind[i] = '0;
            tt_sub[i]  = '0;
            tt_line[i] = '0;
            tt_en[i]   = 0;
            tt_susp[i] = 0;
            tt_pend[i] = 0;
        end
        tt_count    = 0;
        tmr_run     = 0;
        tmr_secs    = '0;
        tmr_elapsed = '0;
        tps         = TPS_RESET;
    endfunction

    function automatic logic [SUB_W-1:0] key_number(input logic [7:0] sc);
        if (sc >= SC_F1 && sc <= SC_F10)
            return sc - SC_F1 + 8'd1;
        case (sc)
            SC_UP:    return KEY_UP;
            SC_LEFT:  return KEY_LEFT;
            SC_RIGHT: return KEY_RIGHT;
            SC_DOWN:  return KEY_DOWN;
            SC_INS:   return KEY_INS;
            SC_DEL:   return KEY_DEL;
            SC_HOME:  return KEY_CUR_HOME;
            SC_END:   return KEY_END;
            SC_PGUP:  return KEY_PGUP;
            SC_PGDN:  return KEY_PGDN;
            default:  return KEY_NONE;
        endcase
    endfunction

    function automatic int find_trap(input logic [KIND_W-1:0] k, input logic [SUB_W-1:0] s);
        for (int i = 0; i < tt_count; i++)
            if (tt_used[i] && tt_kind[i] == k && tt_sub[i] == s)
                return i;
        return SLOTS;
    endfunction

    // an event only marks a trap that is armed
    function automatic void post_event(input logic [KIND_W-1:0] k, input logic [SUB_W-1:0] s);
        int i;
        i = find_trap(k, s);
        if (i < SLOTS && tt_en[i] && !tt_susp[i])
            tt_pend[i] = 1;
    endfunction

    function automatic t_rsp trap_step(input t_req r);
        t_rsp              y;
        int                i;
        bit                hit;
        logic [KIND_W-1:0] k;
        logic [SUB_W-1:0]  s;
        logic [31:0]       due_at;
        y = '0;
        k = r.event_kind;
        s = (k >= KIND_ERROR && k <= KIND_PLAY) ? KEY_NONE : r.sub_event;
        case (r.command)
            CMD_SET: begin
                if (k <= KIND_LAST) begin
                    i = find_trap(k, s);
                    if (i >= SLOTS) begin
                        if (tt_count >= SLOTS) begin
                            y.table_full = 1'b1;
                        end else begin
                            i = tt_count;
                            tt_count++;
                            tt_used[i] = 1;
                            tt_kind[i] = k;
                            tt_sub[i]  = s;
                        end
                    end
                    if (!y.table_full) begin
                        tt_line[i] = r.handler_in;
                        tt_en[i]   = 1;
                        tt_susp[i] = 0;
                        tt_pend[i] = 0;
                        if (k == KIND_TIMER) begin
                            tmr_secs    = r.interval_seconds;
                            tmr_elapsed = '0;
                            tmr_run     = 1;
                        end
                    end
                end
            end
            CMD_ENABLE, CMD_DISABLE, CMD_SUSPEND: begin
                i = (k <= KIND_LAST) ? find_trap(k, s) : SLOTS;
                if (i < SLOTS) begin
                    if (r.command == CMD_ENABLE) begin
                        tt_en[i]   = 1;
                        tt_susp[i] = 0;
                    end else if (r.command == CMD_DISABLE) begin
                        tt_en[i]   = 0;
                        tt_susp[i] = 0;
                        tt_pend[i] = 0;
                    end else begin
                        tt_susp[i] = 1;
                    end
                end
            end
            CMD_EN_ALL: begin
                for (int j = 0; j < SLOTS; j++) begin
                    tt_en[j]   = 1;
                    tt_susp[j] = 0;
                end
            end
            CMD_DIS_ALL: begin
                for (int j = 0; j < SLOTS; j++) begin
                    tt_en[j]   = 0;
                    tt_susp[j] = 0;
                    tt_pend[j] = 0;
                end
                tmr_run = 0;
            end
            CMD_SUSP_ALL: begin
                for (int j = 0; j < SLOTS; j++)
                    tt_susp[j] = 1;
            end
            CMD_KEY: begin
                if (r.pressed && key_number(r.scan_code) != KEY_NONE)
                    post_event(KIND_KEY, key_number(r.scan_code));
            end
            CMD_PEN: begin
                if (r.pressed)
                    post_event(KIND_PEN, KEY_NONE);
            end
            CMD_ERROR: post_event(KIND_ERROR, KEY_NONE);
            CMD_TRIGGER: begin
                if (k <= KIND_LAST)
                    post_event(k, s);
            end
            CMD_TICK: begin
                if (tmr_elapsed != '1)
                    tmr_elapsed = tmr_elapsed + 1'b1;
            end
            CMD_POLL: begin
                due_at = 32'(tmr_secs) * 32'(tps);
                if (tmr_run && tmr_elapsed >= due_at) begin
                    tmr_elapsed = '0;
                    post_event(KIND_TIMER, KEY_NONE);
                end
                hit = 0;
                for (int j = 0; j < tt_count; j++) begin
                    if (!hit && tt_used[j] && tt_pend[j] && tt_en[j] && !tt_susp[j]) begin
                        hit           = 1;
                        tt_pend[j]    = 0;
                        y.handler_out = tt_line[j];
                        y.fired_kind  = tt_kind[j];
                        y.fired_sub   = tt_sub[j];
                    end
                end
            end
            CMD_CLEAR: begin
                for (int j = 0; j < SLOTS; j++) begin
                    tt_used[j] = 0;
                    tt_en[j]   = 0;
                    tt_susp[j] = 0;
                    tt_pend[j] = 0;
                end
                tt_count = 0;
                tmr_run  = 0;
            end
            default: ;
        endcase
        for (int j = 0; j < tt_count; j++) begin
            if (tt_used[j] && tt_en[j] && !tt_susp[j]) begin
                y.any_active = 1'b1;
                if (tt_pend[j])
                    y.any_pending = 1'b1;
            end
        end
        return y;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_req make_req(input logic [CMD_W-1:0] c, input logic [KIND_W-1:0] k,
                                      input logic [SUB_W-1:0] s, input logic [HDL_W-1:0] h,
                                      input logic [15:0] iv, input logic [7:0] sc,
                                      input logic pr);
        t_req r;
        r.command          = c;
        r.event_kind       = k;
        r.sub_event        = s;
        r.handler_in       = h;
        r.interval_seconds = iv;
        r.scan_code        = sc;
        r.pressed          = pr;
        return r;
    endfunction

    function automatic void add_row(input t_req rq, input bit typed, input t_rsp want);
        t_row w;
        w.rq    = rq;
        w.typed = typed;
        w.want  = want;
        rows.insert(rows.size(), w);
    endfunction

    // small pools so sets, triggers and enables hit the same traps
    function automatic logic [SUB_W-1:0] pick_sub(input logic [KIND_W-1:0] k);
        if ($urandom_range(99) < 20 || (k >= KIND_ERROR && k <= KIND_PLAY))
            return SUB_W'($urandom_range(255));
        if (k == KIND_KEY)
            return SUB_W'($urandom_range(1, 20));
        return SUB_W'($urandom_range(3));
    endfunction

    function automatic t_req rand_request(input bit with_clear);
        t_req r;
        int   c;
        int   x;
        r = make_req(CMD_POLL, KIND_W'($urandom_range(7)), SUB_W'($urandom_range(255)),
                     HDL_W'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
        x = $urandom_range(99);
        if (x < 30)      r.event_kind = KIND_KEY;
        else if (x < 97) r.event_kind = KIND_W'(1 + (x - 30) % 6);
        else             r.event_kind = KIND_BAD;
        r.sub_event = pick_sub(r.event_kind);
        x = $urandom_range(99);
        if (x < 60)      r.interval_seconds = 16'($urandom_range(3));
        else if (x < 90) r.interval_seconds = 16'($urandom_range(20));
        c = $urandom_range(99);
        if (c < 18)      r.command = CMD_SET;
        else if (c < 24) r.command = CMD_ENABLE;
        else if (c < 29) r.command = CMD_DISABLE;
        else if (c < 33) r.command = CMD_SUSPEND;
        else if (c < 35) r.command = CMD_EN_ALL;
        else if (c < 36) r.command = CMD_DIS_ALL;
        else if (c < 38) r.command = CMD_SUSP_ALL;
        else if (c < 48) r.command = CMD_KEY;
        else if (c < 51) r.command = CMD_PEN;
        else if (c < 54) r.command = CMD_ERROR;
        else if (c < 64) r.command = CMD_TRIGGER;
        else if (c < 78) r.command = CMD_TICK;
        else if (c < 96) r.command = CMD_POLL;
        else if (c < 99) r.command = with_clear ? CMD_CLEAR : CMD_POLL;
        else             r.command = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        if (r.command == CMD_KEY) begin
            // mostly mapped keys, mostly presses
            if ($urandom_range(99) < 70) begin
                x = $urandom_range(19);
                r.scan_code = (x < 10) ? SC_F1 + 8'(x) : SC_INS + 8'(x - 10);
            end
            r.pressed = ($urandom_range(99) < 85);
        end
        return r;
    endfunction

    // present one request, dropping start on random cycles unless no_idle is set,
    // until it is taken; start stays high on return
    task automatic issue(input t_req r, input bit typed, input t_rsp want, input bit no_idle);
        t_rsp pred;
        bit   taken;
        taken = 1'b0;
        while (!taken) begin
            if (!no_idle && $urandom_range(99) < 24) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                req   <= r;
            end
            @(posedge clk);
            taken = (start === 1'b1 && busy === 1'b0);
        end
        pred = trap_step(r);
        trap_outcomes_due.insert(trap_outcomes_due.size(), typed ? want : pred);
    endtask

    task automatic write_tps(input logic [TPS_W-1:0] v);
        start <= 1'b0;
        while (trap_outcomes_due.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tps = v;
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checking and watchdog
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && strobe) begin
            if (trap_outcomes_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 40)
                    $display("%0t: unexpected result, expected none actual %p", $time, rsp);
            end else begin
                want = trap_outcomes_due.pop_front();
                check_field("handler_out", want.handler_out, rsp.handler_out);
                check_field("fired_kind",  want.fired_kind,  rsp.fired_kind);
                check_field("fired_sub",   want.fired_sub,   rsp.fired_sub);
                check_field("table_full",  want.table_full,  rsp.table_full);
                check_field("any_active",  want.any_active,  rsp.any_active);
                check_field("any_pending", want.any_pending, rsp.any_pending);
            end
        end
    end

    always @(posedge clk) begin
        if ((start && busy === 1'b0) || strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("event_trap_table_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        logic [TPS_W-1:0] phase_tps[PHASES];
        t_rsp             none;
        none      = '0;
        phase_tps = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, TPS_RESET, 16'd1};
        model_reset();

        add_row(make_req(CMD_POLL, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b1, t_rsp'{16'd0, KIND_KEY, 8'd0, 1'b0, 1'b0, 1'b0});
        add_row(make_req(CMD_SET, KIND_KEY, 8'd1, 16'hFFFF, 16'd0, 8'd0, 1'b0),
                1'b1, t_rsp'{16'd0, KIND_KEY, 8'd0, 1'b0, 1'b1, 1'b0});
        add_row(make_req(CMD_KEY, KIND_KEY, 8'd0, 16'd0, 16'd0, SC_F1, 1'b1),
                1'b1, t_rsp'{16'd0, KIND_KEY, 8'd0, 1'b0, 1'b1, 1'b1});
        add_row(make_req(CMD_POLL, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b1, t_rsp'{16'hFFFF, KIND_KEY, 8'd1, 1'b0, 1'b1, 1'b0});
        // zero interval: every poll fires the timer
        add_row(make_req(CMD_SET, KIND_TIMER, 8'hFF, 16'd1, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_POLL, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_SET, KIND_ERROR, 8'hAA, 16'h8000, 16'd0, 8'd0, 1'b1),
                1'b0, none);
        add_row(make_req(CMD_ERROR, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_SUSPEND, KIND_ERROR, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_POLL, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_EN_ALL, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_POLL, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_SET, KIND_PEN, 8'd7, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        // releases are ignored for pen and key
        add_row(make_req(CMD_PEN, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_PEN, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1),
                1'b0, none);
        add_row(make_req(CMD_KEY, KIND_KEY, 8'd0, 16'd0, 16'd0, SC_UP, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_SET, KIND_STICK, 8'hFF, 16'h1234, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_TRIGGER, KIND_STICK, 8'hFF, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_SET, KIND_BAD, 8'd3, 16'h5555, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_TRIGGER, KIND_BAD, 8'd3, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_SET, KIND_SERIAL, 8'd0, 16'hAAAA, 16'hFFFF, 8'hFF, 1'b1),
                1'b0, none);
        add_row(make_req(CMD_SET, KIND_TIMER, 8'd0, 16'h7FFF, 16'hFFFF, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_TICK, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_SUSP_ALL, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_DISABLE, KIND_KEY, 8'd1, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_DIS_ALL, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_SPARE_LO, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b0, none);
        add_row(make_req(CMD_CLEAR, KIND_KEY, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0),
                1'b1, t_rsp'{16'd0, KIND_KEY, 8'd0, 1'b0, 1'b0, 1'b0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[n])
            issue(rows[n].rq, rows[n].typed, rows[n].want, 1'b0);

        // clears only in odd phases so the even ones fill the table
        for (int p = 0; p < PHASES; p++) begin
            write_tps(phase_tps[p]);
            for (int n = 0; n < PHASE_N; n++)
                issue(rand_request(p[0]), 1'b0, none, p == 3);
        end

        start <= 1'b0;
        while (trap_outcomes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (trap_outcomes_due.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results missing, expected %p actual none", $time,
                     trap_outcomes_due.size(), trap_outcomes_due[0]);
        end
        if (fail_count == 0)
            $display("event_trap_table_top verification clean");
        else
            $display("event_trap_table_top verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/ett_pkg.sv
rtl/ett_ctrl.sv
rtl/ett_datapath.sv
rtl/event_trap_table_top.sv
dv/event_trap_table_top_test.sv
